@@ sv/emc_pkg.sv @@
// Shared types, codes and constants of the machine mode controller.
`default_nettype none

package emc_pkg;

    localparam int JOB_ID_BITS = 16;

    typedef enum logic [3:0] {
        OP_START     = 4'd0,
        OP_HOME      = 4'd1,
        OP_FRAME     = 4'd2,
        OP_START_JOB = 4'd3,
        OP_PAUSE     = 4'd4,
        OP_RESUME    = 4'd5,
        OP_STOP      = 4'd6,
        OP_ALARM     = 4'd7,
        OP_POLL      = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        MODE_BOOT    = 3'd0,
        MODE_IDLE    = 3'd1,
        MODE_HOMING  = 3'd2,
        MODE_FRAMING = 3'd3,
        MODE_RUNNING = 3'd4,
        MODE_PAUSED  = 3'd5,
        MODE_ALARM   = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LASER   = 2'd2,
        ST_MOTION  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        MSG_BOOTING        = 4'd0,
        MSG_READY          = 4'd1,
        MSG_HOMING         = 4'd2,
        MSG_FRAMING        = 4'd3,
        MSG_JOB_STARTED    = 4'd4,
        MSG_PAUSED         = 4'd5,
        MSG_RESUMED        = 4'd6,
        MSG_STOPPED        = 4'd7,
        MSG_FRAME_NOT_HOME = 4'd8,
        MSG_RUN_NOT_HOME   = 4'd9,
        MSG_RUN_NO_JOB     = 4'd10,
        MSG_MOTION_FAIL    = 4'd11,
        MSG_HOMED          = 4'd12,
        MSG_FRAME_DONE     = 4'd13,
        MSG_EXT_ALARM      = 4'd14
    } t_msg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_REQUIRE_HOMING  = 2'd0,
        REG_STOP_ON_PAUSE   = 2'd1,
        REG_STOP_ON_ALARM   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic require_homing;
        logic stop_laser_on_pause;
        logic stop_laser_on_alarm;
    } t_cfg;

    typedef struct packed {
        logic [3:0]             opcode;
        logic                   motion_homed;
        logic                   motion_busy;
        logic                   motion_error;
        logic                   job_found;
        logic [JOB_ID_BITS-1:0] job_handle;
        logic                   laser_ack;
        logic                   motion_ack;
    } t_cmd;

    typedef struct packed {
        t_mode                  mode;
        t_msg                   msg;
        logic                   job_held;
        logic [JOB_ID_BITS-1:0] job;
    } t_state;

    typedef struct packed {
        t_mode                  machine_mode;
        t_status                status_code;
        t_msg                   message_code;
        logic                   laser_arm_strobe;
        logic                   laser_disarm_strobe;
        logic                   laser_off_strobe;
        logic                   motion_home_strobe;
        logic                   motion_frame_strobe;
        logic                   motion_stop_strobe;
        logic                   job_active;
        logic [JOB_ID_BITS-1:0] active_job;
    } t_result;

endpackage

`default_nettype wire

@@ sv/emc_cfg_regs.sv @@
// APB-style configuration registers of the machine mode controller.
`default_nettype none

module emc_cfg_regs
    import emc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_REQUIRE_HOMING: n_cfg.require_homing      = pwdata[0];
                REG_STOP_ON_PAUSE:  n_cfg.stop_laser_on_pause = pwdata[0];
                REG_STOP_ON_ALARM:  n_cfg.stop_laser_on_alarm = pwdata[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_REQUIRE_HOMING: prdata = {31'd0, r_cfg.require_homing};
            REG_STOP_ON_PAUSE:  prdata = {31'd0, r_cfg.stop_laser_on_pause};
            REG_STOP_ON_ALARM:  prdata = {31'd0, r_cfg.stop_laser_on_alarm};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{require_homing: 1'b1, stop_laser_on_pause: 1'b1,
                       stop_laser_on_alarm: 1'b1};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

@@ sv/emc_decide.sv @@
// Guarded transition logic: next machine state and the result of one command.
`default_nettype none

module emc_decide
    import emc_pkg::*;
(
    input  wire t_cmd   i_cmd,
    input  wire t_state i_cur,
    input  wire t_cfg   i_cfg,
    output t_state      o_nxt,
    output t_result     o_res
);

    t_op     w_op;
    logic    w_alarm_go;
    logic    w_homing_ok;
    t_state  n_st;
    t_status n_status;
    logic    n_arm, n_disarm, n_off, n_home, n_frame, n_stop;

    assign w_op        = t_op'(i_cmd.opcode);
    // Entering alarm goes through unless a required disarm was not acknowledged.
    assign w_alarm_go  = !i_cfg.stop_laser_on_alarm || i_cmd.laser_ack;
    assign w_homing_ok = !i_cfg.require_homing || i_cmd.motion_homed;

    function automatic t_state enter_alarm(t_state s, t_msg m, logic go);
        t_state r;
        r = s;
        if (go) begin
            r.job_held = 1'b0;
            r.job      = '0;
            r.mode     = MODE_ALARM;
            r.msg      = m;
        end
        return r;
    endfunction

    always_comb begin
        n_st     = i_cur;
        n_status = ST_OK;
        n_arm    = 1'b0;
        n_disarm = 1'b0;
        n_off    = 1'b0;
        n_home   = 1'b0;
        n_frame  = 1'b0;
        n_stop   = 1'b0;
        unique case (w_op)
            OP_START: begin
                n_disarm = 1'b1;
                if (!i_cmd.laser_ack) begin
                    n_status = ST_LASER;
                end else begin
                    n_st.mode = MODE_IDLE;
                    n_st.msg  = MSG_READY;
                end
            end
            OP_HOME: begin
                if (i_cur.mode != MODE_IDLE && i_cur.mode != MODE_ALARM) begin
                    n_status = ST_INVALID;
                end else begin
                    n_st.mode = MODE_HOMING;
                    n_st.msg  = MSG_HOMING;
                    n_home    = 1'b1;
                    n_status  = i_cmd.motion_ack ? ST_OK : ST_MOTION;
                end
            end
            OP_FRAME: begin
                if (i_cur.mode != MODE_IDLE) begin
                    n_status = ST_INVALID;
                end else if (!w_homing_ok) begin
                    n_disarm = i_cfg.stop_laser_on_alarm;
                    n_st     = enter_alarm(i_cur, MSG_FRAME_NOT_HOME, w_alarm_go);
                    n_status = w_alarm_go ? ST_INVALID : ST_LASER;
                end else begin
                    n_st.mode = MODE_FRAMING;
                    n_st.msg  = MSG_FRAMING;
                    n_frame   = 1'b1;
                    n_status  = i_cmd.motion_ack ? ST_OK : ST_MOTION;
                end
            end
            OP_START_JOB: begin
                if (i_cur.mode != MODE_IDLE) begin
                    n_status = ST_INVALID;
                end else if (!w_homing_ok) begin
                    n_disarm = i_cfg.stop_laser_on_alarm;
                    n_st     = enter_alarm(i_cur, MSG_RUN_NOT_HOME, w_alarm_go);
                    n_status = w_alarm_go ? ST_INVALID : ST_LASER;
                end else if (!i_cmd.job_found) begin
                    n_disarm = i_cfg.stop_laser_on_alarm;
                    n_st     = enter_alarm(i_cur, MSG_RUN_NO_JOB, w_alarm_go);
                    n_status = w_alarm_go ? ST_INVALID : ST_LASER;
                end else begin
                    // The handle is taken even when the arm fails.
                    n_st.job_held = 1'b1;
                    n_st.job      = i_cmd.job_handle;
                    n_arm         = 1'b1;
                    if (!i_cmd.laser_ack) begin
                        n_status = ST_LASER;
                    end else begin
                        n_st.mode = MODE_RUNNING;
                        n_st.msg  = MSG_JOB_STARTED;
                    end
                end
            end
            OP_PAUSE: begin
                if (i_cur.mode != MODE_RUNNING) begin
                    n_status = ST_INVALID;
                end else begin
                    n_off = i_cfg.stop_laser_on_pause;
                    if (i_cfg.stop_laser_on_pause && !i_cmd.laser_ack) begin
                        n_status = ST_LASER;
                    end else begin
                        n_st.mode = MODE_PAUSED;
                        n_st.msg  = MSG_PAUSED;
                    end
                end
            end
            OP_RESUME: begin
                if (i_cur.mode != MODE_PAUSED) begin
                    n_status = ST_INVALID;
                end else begin
                    n_arm = 1'b1;
                    if (!i_cmd.laser_ack) begin
                        n_status = ST_LASER;
                    end else begin
                        n_st.mode = MODE_RUNNING;
                        n_st.msg  = MSG_RESUMED;
                    end
                end
            end
            OP_STOP: begin
                n_stop = 1'b1;
                if (!i_cmd.motion_ack) begin
                    n_status = ST_MOTION;
                end else begin
                    n_disarm = 1'b1;
                    if (!i_cmd.laser_ack) begin
                        n_status = ST_LASER;
                    end else begin
                        n_st.job_held = 1'b0;
                        n_st.job      = '0;
                        n_st.mode     = MODE_IDLE;
                        n_st.msg      = MSG_STOPPED;
                    end
                end
            end
            OP_ALARM: begin
                n_disarm = i_cfg.stop_laser_on_alarm;
                n_st     = enter_alarm(i_cur, MSG_EXT_ALARM, w_alarm_go);
                n_status = w_alarm_go ? ST_INVALID : ST_LASER;
            end
            OP_POLL: begin
                if ((i_cur.mode == MODE_HOMING || i_cur.mode == MODE_FRAMING)
                        && !i_cmd.motion_busy) begin
                    if (i_cmd.motion_error) begin
                        n_disarm = i_cfg.stop_laser_on_alarm;
                        n_st     = enter_alarm(i_cur, MSG_MOTION_FAIL, w_alarm_go);
                        n_status = w_alarm_go ? ST_INVALID : ST_LASER;
                    end else begin
                        n_st.mode = MODE_IDLE;
                        n_st.msg  = (i_cur.mode == MODE_HOMING) ? MSG_HOMED
                                                                : MSG_FRAME_DONE;
                    end
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    assign o_nxt = n_st;

    always_comb begin
        o_res.machine_mode        = n_st.mode;
        o_res.status_code         = n_status;
        o_res.message_code        = n_st.msg;
        o_res.laser_arm_strobe    = n_arm;
        o_res.laser_disarm_strobe = n_disarm;
        o_res.laser_off_strobe    = n_off;
        o_res.motion_home_strobe  = n_home;
        o_res.motion_frame_strobe = n_frame;
        o_res.motion_stop_strobe  = n_stop;
        o_res.job_active          = n_st.job_held;
        o_res.active_job          = n_st.job_held ? n_st.job : '0;
    end

endmodule

`default_nettype wire

@@ sv/engraver_machine_mode_controller_core.sv @@
// Top level of the laser machine mode controller: command pipeline and mode state.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_ready) with the
// opcode and the status flags of the motion, laser and job subsystems. Each
// command transfer produces exactly one result transfer on the output channel
// (o_out_valid / i_out_ready) carrying the new machine mode, status code,
// message code, the command strobes issued for that command and the held job.
// An accepted command lands in an input register; once the output register is
// free, the guarded transition logic updates the mode state and the result
// moves into the output register. The block sustains one command per cycle
// while the receiver accepts results, because the input register drains into
// the output register in the same edge that refills it. When the receiver
// stalls, the result holds in the output register, one further command waits
// in the input register, and only then does o_in_ready drop. The mode state
// is updated only when a command moves into the output register, so commands
// take effect strictly in order. Synchronous reset puts the machine in boot
// mode with the booting message, no job held, all configuration bits set, and
// both pipeline registers empty. The user must write configuration through the
// APB-style port only while the block is idle; the block does not enforce this.
`default_nettype none

module engraver_machine_mode_controller_core
    import emc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Command channel.
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [3:0]             i_opcode,
    input  wire logic                   i_motion_homed,
    input  wire logic                   i_motion_busy,
    input  wire logic                   i_motion_error,
    input  wire logic                   i_job_found,
    input  wire logic [JOB_ID_BITS-1:0] i_job_handle,
    input  wire logic                   i_laser_ack,
    input  wire logic                   i_motion_ack,
    // Result channel.
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [2:0]                  o_machine_mode,
    output logic [1:0]                  o_status_code,
    output logic [3:0]                  o_message_code,
    output logic                        o_laser_arm_strobe,
    output logic                        o_laser_disarm_strobe,
    output logic                        o_laser_off_strobe,
    output logic                        o_motion_home_strobe,
    output logic                        o_motion_frame_strobe,
    output logic                        o_motion_stop_strobe,
    output logic                        o_job_active,
    output logic [JOB_ID_BITS-1:0]      o_active_job,
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_state  w_nxt;
    t_result w_res;
    logic    w_in_xfer;
    logic    w_advance;

    logic    r_in_valid;
    t_cmd    r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;

    emc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    emc_decide u_decide (
        .i_cmd (r_in),
        .i_cur (r_state),
        .i_cfg (w_cfg),
        .o_nxt (w_nxt),
        .o_res (w_res)
    );

    always_comb begin
        w_cmd.opcode       = i_opcode;
        w_cmd.motion_homed = i_motion_homed;
        w_cmd.motion_busy  = i_motion_busy;
        w_cmd.motion_error = i_motion_error;
        w_cmd.job_found    = i_job_found;
        w_cmd.job_handle   = i_job_handle;
        w_cmd.laser_ack    = i_laser_ack;
        w_cmd.motion_ack   = i_motion_ack;
    end

    // The buffered command moves on whenever the output register is free or
    // is being emptied in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_BOOT, msg: MSG_BOOTING, job_held: 1'b0,
                             job: '0};
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= w_nxt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= w_cmd;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_machine_mode        = r_out.machine_mode;
    assign o_status_code         = r_out.status_code;
    assign o_message_code        = r_out.message_code;
    assign o_laser_arm_strobe    = r_out.laser_arm_strobe;
    assign o_laser_disarm_strobe = r_out.laser_disarm_strobe;
    assign o_laser_off_strobe    = r_out.laser_off_strobe;
    assign o_motion_home_strobe  = r_out.motion_home_strobe;
    assign o_motion_frame_strobe = r_out.motion_frame_strobe;
    assign o_motion_stop_strobe  = r_out.motion_stop_strobe;
    assign o_job_active          = r_out.job_active;
    assign o_active_job          = r_out.active_job;

endmodule

`default_nettype wire
